[src/opcm_pkg.sv]
// ---------------------------------------------------------------------------
// opcm_pkg: shared types and constants of the onset peak cluster merger
// Field widths, register indexes and the result record passed from the
// cluster logic to the output queue.
// ---------------------------------------------------------------------------
`default_nettype none

package opcm_pkg;

   localparam int POS_W    = 16;
   localparam int WEIGHT_W = 24;
   localparam int DIST_W   = 16;
   localparam int INDEX_W  = 8;
   localparam int DATA_W   = POS_W + WEIGHT_W;

   // Output queue depth; a transfer is taken only while two entries are free.
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

   localparam logic [INDEX_W-1:0] REG_MERGE_MODE   = INDEX_W'(0);
   localparam logic [INDEX_W-1:0] REG_MIN_DISTANCE = INDEX_W'(1);

   localparam logic MODE_KEEP = 1'b0;
   localparam logic MODE_SUM  = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } result_type;

   // Results caused by one onset: a closed cluster first, then a flush.
   typedef struct packed {
      logic       close_valid;
      result_type close_result;
      logic       flush_valid;
      result_type flush_result;
   } result_pair_type;

endpackage

`default_nettype wire

[src/opcm_cluster.sv]
// ---------------------------------------------------------------------------
// opcm_cluster: cluster state and merge decision
// Holds the open cluster and, for each accepted onset, updates it and
// reports the closed and the flushed cluster, if any.
// ---------------------------------------------------------------------------
`default_nettype none

module opcm_cluster (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           item_valid,
   input  wire logic [opcm_pkg::POS_W-1:0]     item_position,
   input  wire logic [opcm_pkg::WEIGHT_W-1:0]  item_weight,
   input  wire logic                           item_last,
   input  wire logic                           merge_mode,
   input  wire logic [opcm_pkg::DIST_W-1:0]    min_distance,
   output opcm_pkg::result_pair_type           results
);
   import opcm_pkg::*;

   logic                cluster_open_ff, cluster_open_in;
   logic [POS_W-1:0]    chosen_position_ff, chosen_position_in;
   logic [WEIGHT_W-1:0] largest_weight_ff, largest_weight_in;
   logic [WEIGHT_W-1:0] weight_total_ff, weight_total_in;
   logic [POS_W-1:0]    gap_reference_ff, gap_reference_in;

   logic signed [POS_W:0] gap_prev, gap_peak, dist_s;
   logic                  joins_prev, joins_peak, joins;
   logic [WEIGHT_W-1:0]   merged_weight;
   logic [WEIGHT_W-1:0]   base_largest, base_total;
   logic [POS_W-1:0]      base_chosen, base_reference;
   logic [WEIGHT_W:0]     sum_wide;
   logic [WEIGHT_W-1:0]   sum_sat;
   logic                  new_peak;
   logic [POS_W-1:0]      next_chosen, next_reference;
   logic [WEIGHT_W-1:0]   next_largest, next_total;

   always_comb begin
      dist_s   = $signed({1'b0, min_distance});
      // Backward positions give a negative gap and therefore join.
      gap_prev = $signed({1'b0, item_position}) - $signed({1'b0, gap_reference_ff});
      gap_peak = $signed({1'b0, item_position}) - $signed({1'b0, chosen_position_ff});
      joins_prev = gap_prev < dist_s;
      joins_peak = gap_peak < dist_s;
      joins      = cluster_open_ff && (joins_prev || joins_peak);

      merged_weight = (merge_mode == MODE_SUM) ? weight_total_ff : largest_weight_ff;

      // When the cluster closes, its merged onset becomes a one-member
      // cluster anchored on its own position before the new onset is tried.
      if (joins_prev) begin
         base_largest   = largest_weight_ff;
         base_total     = weight_total_ff;
         base_chosen    = chosen_position_ff;
         base_reference = gap_reference_ff;
      end else begin
         base_largest   = merged_weight;
         base_total     = merged_weight;
         base_chosen    = chosen_position_ff;
         base_reference = chosen_position_ff;
      end

      sum_wide = {1'b0, base_total} + {1'b0, item_weight};
      sum_sat  = sum_wide[WEIGHT_W] ? WEIGHT_MAX : sum_wide[WEIGHT_W-1:0];
      new_peak = item_weight >= base_largest;

      if (joins) begin
         next_total     = sum_sat;
         next_largest   = new_peak ? item_weight : base_largest;
         next_chosen    = new_peak ? item_position : base_chosen;
         next_reference = (merge_mode == MODE_KEEP) ? item_position : base_reference;
      end else begin
         next_total     = item_weight;
         next_largest   = item_weight;
         next_chosen    = item_position;
         next_reference = item_position;
      end

      results.close_valid           = item_valid && cluster_open_ff && !joins;
      results.close_result.position = chosen_position_ff;
      results.close_result.weight   = merged_weight;
      results.close_result.last     = 1'b0;
      results.flush_valid           = item_valid && item_last;
      results.flush_result.position = next_chosen;
      results.flush_result.weight   = (merge_mode == MODE_SUM) ? next_total : next_largest;
      results.flush_result.last     = 1'b1;

      cluster_open_in    = cluster_open_ff;
      chosen_position_in = chosen_position_ff;
      largest_weight_in  = largest_weight_ff;
      weight_total_in    = weight_total_ff;
      gap_reference_in   = gap_reference_ff;
      if (item_valid) begin
         if (item_last) begin
            cluster_open_in    = 1'b0;
            chosen_position_in = '0;
            largest_weight_in  = '0;
            weight_total_in    = '0;
            gap_reference_in   = '0;
         end else begin
            cluster_open_in    = 1'b1;
            chosen_position_in = next_chosen;
            largest_weight_in  = next_largest;
            weight_total_in    = next_total;
            gap_reference_in   = next_reference;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_open_ff    <= 1'b0;
         chosen_position_ff <= '0;
         largest_weight_ff  <= '0;
         weight_total_ff    <= '0;
         gap_reference_ff   <= '0;
      end else begin
         cluster_open_ff    <= cluster_open_in;
         chosen_position_ff <= chosen_position_in;
         largest_weight_ff  <= largest_weight_in;
         weight_total_ff    <= weight_total_in;
         gap_reference_ff   <= gap_reference_in;
      end
   end

endmodule

`default_nettype wire

[src/onset_peak_cluster_merger_core.sv]
// ---------------------------------------------------------------------------
// onset_peak_cluster_merger_core: onset cluster merger, streaming top level
// Results: the results of an onset are written into the output queue
//   registers when the onset is transferred and leave from its head in order.
// Throughput: one onset per cycle; req_tready drops while fewer than two of
//   the four output queue entries are free, since an onset may cause two.
// Reset: synchronous; clears the open cluster and the output queue and sets
//   merge_mode to 0 and min_distance to 10.
// ---------------------------------------------------------------------------
`default_nettype none

module onset_peak_cluster_merger_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: onset_position [15:0], onset_weight [39:16]
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [opcm_pkg::DATA_W-1:0]   req_tdata,
   input  wire logic                          req_tlast,
   // rsp_tdata: merged_position [15:0], merged_weight [39:16]
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [opcm_pkg::DATA_W-1:0]   rsp_tdata,
   output      logic                          rsp_tlast,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [opcm_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [opcm_pkg::DIST_W-1:0]   csr_data
);
   import opcm_pkg::*;

   logic                merge_mode_ff;
   logic [DIST_W-1:0]   min_distance_ff;
   logic                req_accept, rsp_accept;
   result_pair_type     results;

   result_type          queue_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  push_count;
   result_type          first_entry;
   result_type          head;

   assign csr_ready  = 1'b1;
   assign req_tready = count_ff <= COUNT_W'(FIFO_DEPTH - 2);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_mode_ff   <= MODE_KEEP;
         min_distance_ff <= DIST_W'(10);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MERGE_MODE:   merge_mode_ff   <= csr_data[0];
            REG_MIN_DISTANCE: min_distance_ff <= csr_data;
            default: ;
         endcase
      end
   end

   opcm_cluster cluster_inst (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_accept),
      .item_position (req_tdata[POS_W-1:0]),
      .item_weight   (req_tdata[DATA_W-1:POS_W]),
      .item_last     (req_tlast),
      .merge_mode    (merge_mode_ff),
      .min_distance  (min_distance_ff),
      .results       (results)
   );

   // A closed cluster always goes ahead of the flush of the same onset.
   always_comb begin
      first_entry = results.close_valid ? results.close_result : results.flush_result;
      push_count  = COUNT_W'(results.close_valid) + COUNT_W'(results.flush_valid);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(rsp_accept);
      count_in    = count_ff + push_count - COUNT_W'(rsp_accept);
      head        = queue_ff[rd_ptr_ff];
      rsp_tdata   = {head.weight, head.position};
      rsp_tlast   = head.last;
   end

   always_ff @(posedge clock) begin
      if (results.close_valid || results.flush_valid) begin
         queue_ff[wr_ptr_ff] <= first_entry;
      end
      if (results.close_valid && results.flush_valid) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= results.flush_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[src/opcm_checker.sv]
// ---------------------------------------------------------------------------
// opcm_checker: port-level checks of the onset cluster merger
// Watches the top-level ports and flags queue and handshake slips.
// ---------------------------------------------------------------------------
`default_nettype none

module opcm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          req_tlast,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [opcm_pkg::DATA_W-1:0]   rsp_tdata,
   input wire logic                          rsp_tlast
);
   import opcm_pkg::*;

   // Reset empties the output queue.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // With nothing queued there is always room for another onset.
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output queue");

   // A final onset always flushes a result into the queue.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("final onset gave no result");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind onset_peak_cluster_merger_core opcm_checker checker_inst (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[sim/tb_onset_peak_cluster_merger_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_onset_peak_cluster_merger_core: self-checking bench of the onset merger
// A short table of directed onsets and register writes is followed by random
// onset lists under several settings of merge mode and minimum distance.
// Every result transfer is compared with the cluster predictor kept here.
// ---------------------------------------------------------------------------

module tb_onset_peak_cluster_merger_core;
   import opcm_pkg::*;

   typedef enum logic [1:0] {ROW_ONSET, ROW_MODE, ROW_DISTANCE} row_kind_type;

   // For ROW_MODE and ROW_DISTANCE rows the position field carries the value.
   typedef struct packed {
      row_kind_type        kind;
      logic [POS_W-1:0]    position;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic                known;
      result_type          known_result;
   } directed_row_type;

   localparam result_type NO_RESULT = '0;
   localparam int         PHASE_COUNT = 8;
   localparam int         PHASE_ITEMS = 90;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [INDEX_W-1:0]   csr_index = '0;
   logic [DIST_W-1:0]    csr_data = '0;

   int idle_pct  = 0;
   int stall_pct = 0;
   int error_count = 0;

   // Merged onsets still to come out of the block, oldest first.
   result_type pending_merges[$];

   // Cluster state and register copies of the predictor.
   logic                merge_mode_now = MODE_KEEP;
   logic [DIST_W-1:0]   merge_distance = 16'd10;
   logic                cluster_held = 1'b0;
   logic [POS_W-1:0]    peak_position = '0;
   logic [WEIGHT_W-1:0] peak_weight = '0;
   logic [WEIGHT_W-1:0] weight_sum = '0;
   logic [POS_W-1:0]    gap_origin = '0;

   directed_row_type directed_rows [] = '{
      // Extremes right after reset: a lone onset flushed by last.
      '{ROW_ONSET, 16'd0,     WEIGHT_MAX, 1'b1, 1'b1, '{16'd0, WEIGHT_MAX, 1'b1}},
      '{ROW_ONSET, 16'd65535, 24'd0,      1'b1, 1'b1, '{16'd65535, 24'd0, 1'b1}},
      // Keep mode chain: equal weights go to the later onset, then a close.
      '{ROW_ONSET, 16'd100, 24'd5, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd105, 24'd5, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd114, 24'd3, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd124, 24'd7, 1'b0, 1'b0, NO_RESULT},
      // A position going backwards still joins.
      '{ROW_ONSET, 16'd120, 24'd1, 1'b1, 1'b0, NO_RESULT},
      // Zero weights.
      '{ROW_ONSET, 16'd200, 24'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd201, 24'd0, 1'b1, 1'b1, '{16'd201, 24'd0, 1'b1}},
      // Sum mode with a saturating total and a re-anchored merge.
      '{ROW_MODE,  16'(MODE_SUM), 24'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd300, WEIGHT_MAX, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd305, WEIGHT_MAX, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd309, 24'd1,      1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd312, 24'd2,      1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd400, 24'd8,      1'b1, 1'b0, NO_RESULT},
      // A zero distance merges only backward positions, never equal ones.
      '{ROW_DISTANCE, 16'd0, 24'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd500, 24'd9, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd500, 24'd9, 1'b1, 1'b0, NO_RESULT},
      // Mode and distance change while a cluster is open.
      '{ROW_ONSET, 16'd600, 24'd4, 1'b0, 1'b0, NO_RESULT},
      '{ROW_MODE,  16'(MODE_KEEP), 24'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_DISTANCE, 16'd65535, 24'd0, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd700,   24'd3, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd65535, 24'd1, 1'b0, 1'b0, NO_RESULT},
      '{ROW_ONSET, 16'd0,     24'd2, 1'b1, 1'b0, NO_RESULT}
   };

   onset_peak_cluster_merger_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Cluster predictor
   // ------------------------------------------------------------------
   function automatic logic joins_cluster(input logic [POS_W-1:0] position);
      int gap;
      // Signed gap: a position behind the reference is always close enough.
      gap = int'(position) - int'(gap_origin);
      return gap < int'(merge_distance);
   endfunction

   function automatic logic [WEIGHT_W-1:0] cluster_weight();
      return (merge_mode_now == MODE_KEEP) ? peak_weight : weight_sum;
   endfunction

   task automatic open_cluster(input logic [POS_W-1:0] position,
                               input logic [WEIGHT_W-1:0] weight);
      cluster_held  = 1'b1;
      peak_position = position;
      peak_weight   = weight;
      weight_sum    = weight;
      gap_origin    = position;
   endtask

   task automatic absorb_onset(input logic [POS_W-1:0] position,
                               input logic [WEIGHT_W-1:0] weight);
      logic [WEIGHT_W:0] total;
      total = {1'b0, weight_sum} + {1'b0, weight};
      weight_sum = total[WEIGHT_W] ? WEIGHT_MAX : total[WEIGHT_W-1:0];
      if (weight >= peak_weight) begin
         peak_weight   = weight;
         peak_position = position;
      end
      if (merge_mode_now == MODE_KEEP) begin
         gap_origin = position;
      end
   endtask

   task automatic predict_merge(input logic [POS_W-1:0] position,
                                input logic [WEIGHT_W-1:0] weight,
                                input logic last);
      logic [POS_W-1:0]    closed_position;
      logic [WEIGHT_W-1:0] closed_weight;
      if (!cluster_held) begin
         open_cluster(position, weight);
      end else if (joins_cluster(position)) begin
         absorb_onset(position, weight);
      end else begin
         // The closed cluster becomes a one-member cluster and may absorb the onset.
         closed_position = peak_position;
         closed_weight   = cluster_weight();
         open_cluster(closed_position, closed_weight);
         if (joins_cluster(position)) begin
            absorb_onset(position, weight);
         end else begin
            pending_merges.push_back('{closed_position, closed_weight, 1'b0});
            open_cluster(position, weight);
         end
      end
      if (last) begin
         pending_merges.push_back('{peak_position, cluster_weight(), 1'b1});
         cluster_held  = 1'b0;
         peak_position = '0;
         peak_weight   = '0;
         weight_sum    = '0;
         gap_origin    = '0;
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   task automatic send_onset(input logic [POS_W-1:0] position,
                             input logic [WEIGHT_W-1:0] weight,
                             input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {weight, position};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_merge(position, weight, last);
   endtask

   // Registers change only once the block has drained its results.
   task automatic write_register(input logic [INDEX_W-1:0] index,
                                 input logic [DIST_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_merges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == REG_MERGE_MODE) begin
         merge_mode_now = value[0];
      end else if (index == REG_MIN_DISTANCE) begin
         merge_distance = value;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_merges.size() == 0) begin
            $error("result transfer with none expected: position %0d weight %0d last %0d",
                   rsp_tdata[POS_W-1:0], rsp_tdata[DATA_W-1:POS_W], rsp_tlast);
            error_count++;
         end else begin
            want = pending_merges.pop_front();
            if (rsp_tdata[POS_W-1:0] !== want.position) begin
               $error("merged_position: expected %0d, actual %0d",
                      want.position, rsp_tdata[POS_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[DATA_W-1:POS_W] !== want.weight) begin
               $error("merged_weight: expected %0d, actual %0d",
                      want.weight, rsp_tdata[DATA_W-1:POS_W]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("merged_last: expected %0d, actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int                  span;
      int                  pick;
      logic [POS_W-1:0]    cursor;
      logic [POS_W-1:0]    position;
      logic [WEIGHT_W-1:0] weight;
      logic [DIST_W-1:0]   distance;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table, with light idling on both sides.
      idle_pct  = 25;
      stall_pct = 25;
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_MODE: begin
               write_register(REG_MERGE_MODE, directed_rows[i].position);
            end
            ROW_DISTANCE: begin
               write_register(REG_MIN_DISTANCE, directed_rows[i].position);
            end
            default: begin
               send_onset(directed_rows[i].position, directed_rows[i].weight,
                          directed_rows[i].last);
               // A known row is a final onset; its flush is the newest entry.
               if (directed_rows[i].known) begin
                  void'(pending_merges.pop_back());
                  pending_merges.push_back(directed_rows[i].known_result);
               end
            end
         endcase
      end

      // Random onset lists; each phase picks a setting and an idling pattern.
      cursor = '0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: distance = 16'd10;
            1: distance = 16'd0;
            2: distance = 16'd65535;
            3: distance = 16'd1;
            4: distance = 16'($urandom_range(2, 64));
            5: distance = 16'd3;
            6: distance = 16'($urandom_range(100, 2000));
            default: distance = 16'($urandom);
         endcase
         write_register(REG_MERGE_MODE, (phase % 2 == 1) ? 16'(MODE_SUM) : 16'(MODE_KEEP));
         write_register(REG_MIN_DISTANCE, distance);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         // Steps around the distance give a mix of joins and closes.
         span = (distance < 16'd1000) ? 2 * int'(distance) + 2 : 3000;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               cursor = 16'($urandom);
            end else begin
               cursor = cursor + 16'($urandom_range(0, span));
            end
            position = cursor;
            pick = $urandom_range(99);
            if (pick < 10) begin
               weight = WEIGHT_MAX;
            end else if (pick < 20) begin
               weight = '0;
            end else if (pick < 50) begin
               weight = 24'($urandom_range(0, 4095));
            end else begin
               weight = 24'($urandom);
            end
            send_onset(position, weight, ($urandom_range(15) == 0) || (n == PHASE_ITEMS - 1));
         end
      end

      req_tvalid <= 1'b0;
      while (pending_merges.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[sim.f]
src/opcm_pkg.sv
src/opcm_cluster.sv
src/onset_peak_cluster_merger_core.sv
src/opcm_checker.sv
sim/tb_onset_peak_cluster_merger_core.sv
